// File: rtl/lss_pkg.sv
// Shared types for the LIFO stack with linear search.
// Request/response payloads, opcode and status codes, controller state,
// and the command/status structs that join the controller and datapath.
package lss_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 7;

  typedef logic [DataW-1:0]  value_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH
  } state_e;

  typedef struct packed {
    opcode_e opcode;
    value_t  data_word;
  } in_req_t;

  typedef struct packed {
    status_e status;
    value_t  value;
    count_t  count;
  } out_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic    push_wr;     // write the incoming word at the top slot
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    key_load;    // capture the incoming word
    logic    rd_en;
    logic    rd_top;      // read at count-1, else at ptr-1
    logic    ptr_top;     // load walk pointer with count-1
    logic    ptr_dec;
    logic    out_load;
    logic    out_use_rd;  // response value from read data, else zero
    status_e out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic hit;
    logic ptr_zero;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/lss_ctrl.sv
// Controller FSM of the LIFO stack with search.
// Decodes requests and sequences pop reads and the top-down search walk.
// Depends on lss_pkg.
module lss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  lss_pkg::opcode_e opcode_i,
  output logic             in_stall_o,
  input  lss_pkg::stat_t   stat_i,
  output lss_pkg::cmd_t    cmd_o
);
  import lss_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept     = (state_q == S_IDLE) && in_valid_i && stat_i.out_free;
  assign in_stall_o = (state_q != S_IDLE) || !stat_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_POP && !stat_i.empty) begin
            state_d = S_POP;
          end else if (opcode_i == OP_SEARCH && !stat_i.empty) begin
            state_d = S_SEARCH;
          end
        end
      end
      S_POP: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SEARCH: begin
        if ((stat_i.hit || stat_i.ptr_zero) && stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.key_load = 1'b1;
          unique case (opcode_i)
            OP_PUSH: begin
              cmd_o.out_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = ST_OVERFLOW;
              end else begin
                cmd_o.push_wr = 1'b1;
                cmd_o.cnt_inc = 1'b1;
              end
            end
            OP_POP: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_UNDERFLOW;
              end else begin
                cmd_o.cnt_dec = 1'b1;
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_top  = 1'b1;
              end
            end
            OP_SEARCH: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_NOT_FOUND;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_top  = 1'b1;
                cmd_o.ptr_top = 1'b1;
              end
            end
            OP_CLEAR: begin
              cmd_o.cnt_clr  = 1'b1;
              cmd_o.out_load = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_use_rd = 1'b1;
        end
      end
      S_SEARCH: begin
        if (stat_i.hit) begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_use_rd = 1'b1;
          end
        end else if (stat_i.ptr_zero) begin
          if (stat_i.out_free) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_status = ST_NOT_FOUND;
          end
        end else begin
          // step one entry further down
          cmd_o.rd_en   = 1'b1;
          cmd_o.ptr_dec = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/lss_datapath.sv
// Datapath of the LIFO stack with search: entry memory, count, walk
// pointer, key register, comparator and response register.
// Depends on lss_pkg.
module lss_datapath #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lss_pkg::value_t   data_word_i,
  input  lss_pkg::cmd_t     cmd_i,
  output lss_pkg::stat_t    stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lss_pkg::out_rsp_t out_rsp_o
);
  import lss_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] key_q;
  logic [WIDTH-1:0] word;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    top_addr, rd_addr;
  logic             out_valid_q, out_valid_d;
  out_rsp_t         out_q, out_d;

  assign word     = WIDTH'(data_word_i);
  assign top_addr = AW'(count_q - 1'b1);
  assign rd_addr  = cmd_i.rd_top ? top_addr : (ptr_q - 1'b1);

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_wr) begin
      mem[AW'(count_q)] <= word;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (cmd_i.key_load) begin
      key_q <= word;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_clr) begin
      count_d = '0;
    end else if (cmd_i.cnt_inc) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_top) begin
      ptr_d = top_addr;
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
  end

  // response register
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_d.status = cmd_i.out_status;
    out_d.value  = cmd_i.out_use_rd ? value_t'(rd_q) : '0;
    out_d.count  = count_t'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.hit      = (rd_q == key_q);
  assign stat_o.ptr_zero = (ptr_q == '0);

endmodule

// File: rtl/lifo_stack_with_search_top.sv
// LIFO stack with linear search: top level.
// Request channel: in_valid_i / in_stall_o carry in_req_i (opcode, data_word).
// Response channel: out_valid_o / out_stall_i carry out_rsp_o (status,
// value, count). A transfer happens on a clock edge with valid high and
// stall low. Every request gives exactly one response, in request order.
// Push, clear, pop underflow, push overflow and search on an empty stack
// are decided in the accept cycle: response is valid the next cycle,
// one request per cycle while the response is not stalled. Pop loads the
// response after the registered memory read. Search reads one entry per
// cycle from the top down through the single memory read port.
// A new request is taken only once the previous one has finished and the
// response register is empty or being drained in that same cycle.
// While the receiver stalls, the response holds and the block holds off
// further requests behind it.
// Reset clears the entry count and the response valid; stored entries
// are not cleared and need no clearing pass.
// Depends on lss_pkg, lss_ctrl, lss_datapath.
module lifo_stack_with_search_top #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lss_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lss_pkg::out_rsp_t out_rsp_o
);
  import lss_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_req_i.opcode),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lss_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_word_i (in_req_i.data_word),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
